// File: rtl/slt_pkg.sv
// Shared types, codes and defaults for the sorted list table.
package slt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } slt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // load the incoming transaction
        logic update;    // apply the operation and load the result register
    } slt_ctrl_t;

endpackage

// File: rtl/slt_ctrl.sv
// Controller state machine for the sorted list table.
module slt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output slt_pkg::slt_ctrl_t ctrl
);
    import slt_pkg::*;

    slt_state_t state_reg;
    slt_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load_ok;
    logic       accept;

    // result slot is free or is being taken this cycle
    assign load_ok = !out_valid_reg || !out_stall;
    assign accept  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (load_ok)
                begin
                    state_next = accept ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = !((state_reg == ST_IDLE) || ((state_reg == ST_UPD) && load_ok));
        ctrl.capture   = accept;
        ctrl.update    = (state_reg == ST_UPD) && load_ok;
        out_valid_next = ctrl.update || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/slt_datapath.sv
// Datapath: row of compare-and-shift entries, count and result register.
module slt_datapath #(
    parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  slt_pkg::slt_ctrl_t                 ctrl,
    input  logic [slt_pkg::CMD_W-1:0]          cmd,
    input  logic signed [DATA_WIDTH-1:0]       key_value,
    output logic [slt_pkg::STATUS_W-1:0]       status,
    output logic                               found,
    output logic signed [DATA_WIDTH-1:0]       removed_value,
    output logic [slt_pkg::COUNT_FIELD_W-1:0]  entry_count
);
    import slt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CMD_W-1:0]             cmd_reg;
    logic signed [DATA_WIDTH-1:0] key_reg;
    logic signed [DATA_WIDTH-1:0] entries_reg [CAPACITY];
    logic signed [DATA_WIDTH-1:0] ins_next    [CAPACITY];
    logic signed [DATA_WIDTH-1:0] rem_next    [CAPACITY];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CAPACITY-1:0]          lt_next;
    logic [CAPACITY-1:0]          eq_next;
    logic [CAPACITY-1:0]          lt_reg;
    logic                         present_reg;
    logic                         full;
    logic                         do_insert;
    logic                         do_remove;
    logic [STATUS_W-1:0]          status_next;
    logic [CNT_W+COUNT_FIELD_W-1:0] count_wide;

    logic [STATUS_W-1:0]          status_reg;
    logic                         found_reg;
    logic signed [DATA_WIDTH-1:0] removed_reg;
    logic [COUNT_FIELD_W-1:0]     entry_count_reg;

    // per-entry compare and shift
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_entry
        logic in_use;
        assign in_use     = count_reg > CNT_W'(i);
        assign lt_next[i] = in_use && (entries_reg[i] < key_reg);
        assign eq_next[i] = in_use && (entries_reg[i] == key_reg);

        if (i == 0)
        begin : g_first
            assign ins_next[i] = lt_reg[i] ? entries_reg[i] : key_reg;
        end
        else
        begin : g_rest
            assign ins_next[i] = lt_reg[i]     ? entries_reg[i] :
                                 lt_reg[i-1]   ? key_reg :
                                                 entries_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rem_next[i] = entries_reg[i];
        end
        else
        begin : g_mid
            assign rem_next[i] = lt_reg[i] ? entries_reg[i] : entries_reg[i+1];
        end
    end

    assign full      = count_reg >= CNT_W'(CAPACITY);
    assign do_insert = (cmd_reg == CMD_INSERT) && !full;
    assign do_remove = (cmd_reg == CMD_REMOVE) && present_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        status_next = STATUS_OK;
        if ((cmd_reg == CMD_INSERT) && full)
        begin
            status_next = STATUS_FULL;
        end
        else if (((cmd_reg == CMD_SEARCH) || (cmd_reg == CMD_REMOVE)) && !present_reg)
        begin
            status_next = STATUS_NOT_FOUND;
        end

        count_wide = {{COUNT_FIELD_W{1'b0}}, count_next};
    end

    // transaction capture and compare flags
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= cmd;
            key_reg <= key_value;
        end
        lt_reg      <= lt_next;
        present_reg <= |eq_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ctrl.update && do_insert)
            begin
                entries_reg[i] <= ins_next[i];
            end
            else if (ctrl.update && do_remove)
            begin
                entries_reg[i] <= rem_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.update)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            status_reg      <= status_next;
            found_reg       <= present_reg;
            removed_reg     <= do_remove ? key_reg : '0;
            entry_count_reg <= count_wide[COUNT_FIELD_W-1:0];
        end
    end

    assign status        = status_reg;
    assign found         = found_reg;
    assign removed_value = removed_reg;
    assign entry_count   = entry_count_reg;

endmodule

// File: rtl/sorted_list_table.sv
// Top level of the sorted list table: controller plus compare-and-shift datapath.
//
// Keeps up to CAPACITY signed DATA_WIDTH-bit values in ascending order, duplicates
// allowed. Each input transaction carries a command (insert, search, remove) and a
// value; each produces exactly one result transaction with status, found flag, the
// removed value (zero unless a remove succeeded) and the entry count afterwards,
// reported in its low 5 bits. Insert places the value after all smaller entries;
// a full table leaves the contents alone and reports STATUS_FULL. Remove takes out
// one equal entry. An accepted transaction passes a compare step and then an update
// step; the next transaction can be accepted at the edge that registers its result,
// so a new transaction is taken only once the last one is through. The compare step
// registers the compare flags of every entry against the value; the update step
// applies the one-step shift of the whole row and the count. A stalled result
// holds the block in its update step until the result slot frees. No clearing pass
// follows reset: entries past the count are never consulted.
module sorted_list_table #(
    parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [slt_pkg::CMD_W-1:0]          cmd,
    input  logic signed [DATA_WIDTH-1:0]       key_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [slt_pkg::STATUS_W-1:0]       status,
    output logic                               found,
    output logic signed [DATA_WIDTH-1:0]       removed_value,
    output logic [slt_pkg::COUNT_FIELD_W-1:0]  entry_count
);
    import slt_pkg::*;

    slt_ctrl_t ctrl;

    // sequencing: idle -> compare -> update
    slt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    // entry row, count and result register
    slt_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cmd           (cmd),
        .key_value     (key_value),
        .status        (status),
        .found         (found),
        .removed_value (removed_value),
        .entry_count   (entry_count)
    );

`ifndef SYNTHESIS
    // a capture is always followed by the compare cycle, which takes no transaction
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> in_stall)
        else $error("transaction accepted during compare cycle");

    // a nonzero removed value only comes from a successful remove
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (removed_value != '0)) |-> (found && (status == STATUS_OK)))
        else $error("removed value without a successful remove");

    // not found never pairs with found
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_NOT_FOUND)) |-> !found)
        else $error("not-found status with found flag set");

    // the result register loads only when the slot is free or being drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |-> (!out_valid || !out_stall))
        else $error("result overwritten while stalled");
`endif

endmodule
